// ===== rtl/pts_pkg.sv =====
package pts_pkg;

    // table geometry
    localparam int NUM_TASKS   = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int TIDX_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    // fixed field widths
    localparam int CMD_W     = 3;
    localparam int TASK_W    = 4;
    localparam int FIELD_W   = 32;
    localparam int SRC_W     = 2;
    localparam int MASK_W    = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [TIDX_W-1:0]      t_tidx;

    localparam t_count CNT_MAX  = '1;
    localparam t_tidx  IDX_LAST = TIDX_W'(NUM_TASKS - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK          = 3'd0,
        CMD_SET_PERIODIC  = 3'd1,
        CMD_SET_ONCE      = 3'd2,
        CMD_DISABLE       = 3'd3,
        CMD_REQUEST       = 3'd4,
        CMD_CLEAR_TIMEOUT = 3'd5
    } t_cmd;

    typedef enum logic [SRC_W-1:0] {
        SRC_PERIODIC = 2'd0,
        SRC_ONCE     = 2'd1,
        SRC_TIMEOUT  = 2'd2,
        SRC_EVENT    = 2'd3
    } t_src;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } t_state;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_OFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd1;

    // result of the shared add/compare unit
    typedef struct packed {
        t_count count;
        logic   due;
    } t_alu_res;

    // clamp a 32-bit field into the counter range
    function automatic t_count clamp_field(input logic [FIELD_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        if (w > 64'(CNT_MAX)) begin
            return CNT_MAX;
        end
        return w[COUNT_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/periodic_task_scheduler.sv =====
// Periodic task scheduler.
//
// Command channel: an item is taken when start is high and busy is low.
// Set periodic, set once, disable, request and clear timeout update the
// task table in the accept cycle and raise no result; busy stays low.
// A tick with nonzero elapsed_ticks raises busy and walks the table, one
// task per cycle through a single saturating add/compare unit, followed
// by a drain state that puts out the held-back result.
// A tick with zero elapsed_ticks is a no-op.
// Result channel: each run result sits on o_run_task/o_run_source/o_last
// for one cycle with o_valid high. A found result is held back until the
// next one is found (or the walk ends) so o_last can be set on the final
// one, and the final one is on the ports in the first cycle with busy low.
// No backpressure.
// Config channel: o_cfg_ready is always high; index 0 is the periodic-off
// mask, index 1 the timeout mask, other indexes are dropped.
// Reset (synchronous, active low): all tasks disabled, counters, periods
// and flags cleared, masks cleared.
module periodic_task_scheduler (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [pts_pkg::CMD_W-1:0]              i_cmd,
    input  logic [pts_pkg::TASK_W-1:0]             i_task_index,
    input  logic [pts_pkg::FIELD_W-1:0]            i_period_ticks,
    input  logic [pts_pkg::FIELD_W-1:0]            i_elapsed_ticks,
    output logic                                   o_valid,
    output logic [pts_pkg::TASK_W-1:0]             o_run_task,
    output logic [pts_pkg::SRC_W-1:0]              o_run_source,
    output logic                                   o_last,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pts_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [pts_pkg::MASK_W-1:0]             i_cfg_data
);
    import pts_pkg::*;

    // task table
    t_count r_elapsed  [NUM_TASKS];
    t_count r_period   [NUM_TASKS];
    logic   r_disabled [NUM_TASKS];
    logic   r_once     [NUM_TASKS];
    logic   r_request  [NUM_TASKS];

    // config masks
    logic [MASK_W-1:0] r_po_mask;
    logic [MASK_W-1:0] r_to_mask;

    // sequencer
    t_state r_state, n_state;
    t_tidx  r_idx,   n_idx;
    t_count r_step;

    // held-back result, used to mark the last one
    logic   r_pend_v,    n_pend_v;
    t_tidx  r_pend_task, n_pend_task;
    t_src   r_pend_src,  n_pend_src;

    // output register
    logic   r_out_v,    n_out_v;
    t_tidx  r_out_task, n_out_task;
    t_src   r_out_src,  n_out_src;
    logic   r_out_last, n_out_last;

    logic              accept;
    logic              walking;
    logic              fire;
    logic              hit;
    t_src              walk_src;
    t_alu_res          alu;
    logic [MASK_W-1:0] po_sh;
    logic [MASK_W-1:0] to_sh;
    logic [MASK_W-1:0] cmd_to_sh;
    logic              idx_ok;
    t_tidx             cmd_tidx;

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign walking     = (r_state == ST_WALK);
    assign o_cfg_ready = 1'b1;

    assign idx_ok   = (32'(i_task_index) < NUM_TASKS);
    assign cmd_tidx = TIDX_W'(i_task_index);

    // shared saturating add + due compare, one task per cycle
    pts_alu u_alu (
        .i_count  (r_elapsed[r_idx]),
        .i_step   (r_step),
        .i_period (r_period[r_idx]),
        .o_res    (alu)
    );

    // mask bits; tasks past the mask width shift in zeros
    assign po_sh     = r_po_mask >> r_idx;
    assign to_sh     = r_to_mask >> r_idx;
    assign cmd_to_sh = r_to_mask >> cmd_tidx;

    // run reason, in priority order
    always_comb begin
        hit      = 1'b1;
        walk_src = SRC_PERIODIC;
        priority if (!po_sh[0] && alu.due) begin
            walk_src = SRC_PERIODIC;
        end else if (r_once[r_idx] && alu.due) begin
            walk_src = SRC_ONCE;
        end else if (to_sh[0] && alu.due) begin
            walk_src = SRC_TIMEOUT;
        end else if (r_request[r_idx]) begin
            walk_src = SRC_EVENT;
        end else begin
            hit = 1'b0;
        end
    end

    assign fire = walking && !r_disabled[r_idx] && hit;

    // next state and result staging
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend_v    = r_pend_v;
        n_pend_task = r_pend_task;
        n_pend_src  = r_pend_src;
        n_out_v     = 1'b0;
        n_out_task  = r_out_task;
        n_out_src   = r_out_src;
        n_out_last  = r_out_last;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_cmd == CMD_TICK) && (i_elapsed_ticks != '0)) begin
                    n_state = ST_WALK;
                    n_idx   = '0;
                end
            end
            ST_WALK: begin
                if (fire) begin
                    // a newer result exists, so the held one is not last
                    if (r_pend_v) begin
                        n_out_v    = 1'b1;
                        n_out_task = r_pend_task;
                        n_out_src  = r_pend_src;
                        n_out_last = 1'b0;
                    end
                    n_pend_v    = 1'b1;
                    n_pend_task = r_idx;
                    n_pend_src  = walk_src;
                end
                if (r_idx == IDX_LAST) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_FLUSH: begin
                if (r_pend_v) begin
                    n_out_v    = 1'b1;
                    n_out_task = r_pend_task;
                    n_out_src  = r_pend_src;
                    n_out_last = 1'b1;
                end
                n_pend_v = 1'b0;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state  = ST_IDLE;
                n_pend_v = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_task <= n_pend_task;
        r_pend_src  <= n_pend_src;
        r_out_task  <= n_out_task;
        r_out_src   <= n_out_src;
        r_out_last  <= n_out_last;
        if (accept) begin
            r_step <= clamp_field(i_elapsed_ticks);
        end
    end

    assign o_valid      = r_out_v;
    assign o_run_task   = TASK_W'(r_out_task);
    assign o_run_source = r_out_src;
    assign o_last       = r_out_last;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_po_mask <= '0;
            r_to_mask <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PERIODIC_OFF: r_po_mask <= i_cfg_data;
                CFG_TIMEOUT:      r_to_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // task table: walk updates one entry per cycle, commands write one entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_elapsed[i]  <= '0;
                r_period[i]   <= '0;
                r_disabled[i] <= 1'b1;
                r_once[i]     <= 1'b0;
                r_request[i]  <= 1'b0;
            end
        end else if (walking) begin
            if (fire) begin
                r_elapsed[r_idx] <= '0;
                r_request[r_idx] <= 1'b0;
                if (r_once[r_idx]) begin
                    r_disabled[r_idx] <= 1'b1;
                end
            end else begin
                r_elapsed[r_idx] <= alu.count;
            end
        end else if (accept && idx_ok) begin
            unique case (i_cmd)
                CMD_SET_PERIODIC, CMD_SET_ONCE: begin
                    r_once[cmd_tidx]     <= (i_cmd == CMD_SET_ONCE);
                    r_disabled[cmd_tidx] <= 1'b0;
                    r_period[cmd_tidx]   <= clamp_field(i_period_ticks);
                    r_elapsed[cmd_tidx]  <= '0;
                end
                CMD_DISABLE: begin
                    r_disabled[cmd_tidx] <= 1'b1;
                end
                CMD_REQUEST: begin
                    r_request[cmd_tidx]  <= 1'b1;
                    r_disabled[cmd_tidx] <= 1'b0;
                end
                CMD_CLEAR_TIMEOUT: begin
                    if (cmd_to_sh[0]) begin
                        r_elapsed[cmd_tidx]  <= '0;
                        r_disabled[cmd_tidx] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // results come only out of a walk or its drain cycle
    a_out_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == ST_WALK || $past(r_state) == ST_FLUSH))
        else $error("result outside a tick walk");

    // a nonzero tick always starts a walk
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_TICK && i_elapsed_ticks != '0) |=> walking)
        else $error("tick did not start a walk");

    // nothing stays held back once a tick is over
    a_flush_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |=> !r_pend_v)
        else $error("held result left after drain");

    // a task that runs has its counter cleared
    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_elapsed[$past(r_idx)] == '0))
        else $error("counter not cleared after run");

endmodule

// ===== rtl/pts_alu.sv =====
module pts_alu (
    input  pts_pkg::t_count   i_count,
    input  pts_pkg::t_count   i_step,
    input  pts_pkg::t_count   i_period,
    output pts_pkg::t_alu_res o_res
);
    import pts_pkg::*;

    logic [COUNT_WIDTH:0] sum;
    t_count               cnt;

    assign sum = {1'b0, i_count} + {1'b0, i_step};

    // saturate on carry, then compare against the period
    always_comb begin
        cnt         = sum[COUNT_WIDTH] ? CNT_MAX : sum[COUNT_WIDTH-1:0];
        o_res.count = cnt;
        o_res.due   = (cnt >= i_period);
    end

endmodule

// ===== sim/tb_periodic_task_scheduler.sv =====
module tb_periodic_task_scheduler;
    import pts_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 7;
    // A tick holds busy only through its walk and drain, so a run of
    // STALL_LIMIT quiet cycles can only mean a hang.
    localparam int STALL_LIMIT  = 1000;
    // The final result arrives in the first cycle with busy low. This margin covers
    // that and any result that should not come.
    localparam int DRAIN_CYCLES = 24;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 75;
    localparam int PREDICTED    = -1;   // the predictor decides the results of this row

    // Command and register codes that the block must drop
    localparam logic [CMD_W-1:0]     CMD_RSVD_6  = 3'd6;
    localparam logic [CMD_W-1:0]     CMD_RSVD_7  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [TASK_W-1:0] run_idx;
        t_src              source;
        logic              last;
    } run_t;

    // One command item. When n_runs is not PREDICTED, it gives the expected
    // result count (0 or 1) directly, with run_idx and source.
    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [TASK_W-1:0]  idx;
        logic [FIELD_W-1:0] per;
        logic [FIELD_W-1:0] el;
        int                 n_runs;
        logic [TASK_W-1:0]  run_idx;
        t_src               source;
    } cmd_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     i_cmd;
    logic [TASK_W-1:0]    i_task_index;
    logic [FIELD_W-1:0]   i_period_ticks;
    logic [FIELD_W-1:0]   i_elapsed_ticks;
    logic                 o_valid;
    logic [TASK_W-1:0]    o_run_task;
    logic [SRC_W-1:0]     o_run_source;
    logic                 o_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [MASK_W-1:0]    i_cfg_data;

    periodic_task_scheduler DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_task_index    (i_task_index),
        .i_period_ticks  (i_period_ticks),
        .i_elapsed_ticks (i_elapsed_ticks),
        .o_valid         (o_valid),
        .o_run_task      (o_run_task),
        .o_run_source    (o_run_source),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scheduler predictor: a copy of the task table and of both masks
    // ------------------------------------------------------------------
    t_count            elapsed_cnt [NUM_TASKS];
    t_count            period_val  [NUM_TASKS];
    logic              dis_flag    [NUM_TASKS];
    logic              once_flag   [NUM_TASKS];
    logic              req_flag    [NUM_TASKS];
    logic [MASK_W-1:0] off_mask;
    logic [MASK_W-1:0] tmo_mask;

    run_t tick_runs[$];      // runs caused by the item just accepted
    run_t pending_runs[$];   // runs still expected from the block, oldest first

    int fail_cnt  = 0;
    int stall_cnt = 0;
    int idle_pct  = 0;       // chance of a sender gap cycle, in percent

    function automatic void table_reset();
        for (int i = 0; i < NUM_TASKS; i++) begin
            elapsed_cnt[i] = '0;
            period_val[i]  = '0;
            dis_flag[i]    = 1'b1;
            once_flag[i]   = 1'b0;
            req_flag[i]    = 1'b0;
        end
        off_mask = '0;
        tmo_mask = '0;
    endfunction

    // Counter advance saturates at the top of the counter range
    function automatic t_count add_sat(input t_count a, input logic [FIELD_W-1:0] e);
        logic [64:0] s;
        s = 65'(a) + 65'(e);
        return (s > 65'(CNT_MAX)) ? CNT_MAX : t_count'(s);
    endfunction

    // Tasks past the mask width never have a mask bit set
    function automatic logic mask_hit(input logic [MASK_W-1:0] m, input int i);
        return (i < MASK_W) ? m[i] : 1'b0;
    endfunction

    // Applies one accepted command to the table and fills tick_runs
    function automatic void table_step(input logic [CMD_W-1:0] cmd,
                                       input logic [TASK_W-1:0] idx,
                                       input logic [FIELD_W-1:0] per,
                                       input logic [FIELD_W-1:0] el);
        logic due;
        logic hit;
        t_src src;
        run_t r;
        tick_runs.delete();
        if (cmd == CMD_TICK) begin
            // A tick with zero elapsed is a no-op
            if (el == '0) return;
            // Every counter advances, disabled tasks too
            for (int i = 0; i < NUM_TASKS; i++) elapsed_cnt[i] = add_sat(elapsed_cnt[i], el);
            for (int i = 0; i < NUM_TASKS; i++) begin
                due = elapsed_cnt[i] >= period_val[i];
                hit = 1'b1;
                src = SRC_PERIODIC;
                // The first matching reason wins
                if (dis_flag[i]) hit = 1'b0;
                else if (!mask_hit(off_mask, i) && due) src = SRC_PERIODIC;
                else if (once_flag[i] && due) src = SRC_ONCE;
                else if (mask_hit(tmo_mask, i) && due) src = SRC_TIMEOUT;
                else if (req_flag[i]) src = SRC_EVENT;
                else hit = 1'b0;
                if (hit) begin
                    // A run-once task turns itself off but keeps its once flag
                    if (once_flag[i]) dis_flag[i] = 1'b1;
                    req_flag[i]    = 1'b0;
                    elapsed_cnt[i] = '0;
                    tick_runs.push_back('{run_idx: TASK_W'(i), source: src, last: 1'b0});
                end
            end
            if (tick_runs.size() != 0) begin
                r = tick_runs.pop_back();
                r.last = 1'b1;
                tick_runs.push_back(r);
            end
            return;
        end
        if (int'(idx) >= NUM_TASKS) return;
        case (cmd)
            CMD_SET_PERIODIC, CMD_SET_ONCE: begin
                once_flag[idx]   = (cmd == CMD_SET_ONCE);
                dis_flag[idx]    = 1'b0;
                period_val[idx]  = (64'(per) > 64'(CNT_MAX)) ? CNT_MAX : t_count'(per);
                elapsed_cnt[idx] = '0;
            end
            CMD_DISABLE: dis_flag[idx] = 1'b1;
            CMD_REQUEST: begin
                req_flag[idx] = 1'b1;
                dis_flag[idx] = 1'b0;
            end
            CMD_CLEAR_TIMEOUT: begin
                // Only a timeout task can be cleared
                if (mask_hit(tmo_mask, idx)) begin
                    elapsed_cnt[idx] = '0;
                    dis_flag[idx]    = 1'b0;
                end
            end
            default: ;   // reserved codes do nothing
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers: inputs change on the falling edge
    // ------------------------------------------------------------------
    cmd_row_t directed_rows[$];

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [TASK_W-1:0] idx,
                           input logic [FIELD_W-1:0] per, input logic [FIELD_W-1:0] el,
                           input int n_runs, input logic [TASK_W-1:0] run_idx,
                           input t_src source);
        directed_rows.push_back('{cmd, idx, per, el, n_runs, run_idx, source});
    endtask

    // Runs from this task start at a falling edge and end at one. Start stays
    // high at the end, so back-to-back items never lower it and raise it again
    // in the same step.
    task automatic send_cmd(input cmd_row_t row);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start           <= 1'b1;
        i_cmd           <= row.cmd;
        i_task_index    <= row.idx;
        i_period_ticks  <= row.per;
        i_elapsed_ticks <= row.el;
        // Accepted at the first rising edge with busy low
        do @(posedge i_clk); while (busy);
        table_step(row.cmd, row.idx, row.per, row.el);
        if (row.n_runs == PREDICTED) begin
            foreach (tick_runs[k]) pending_runs.push_back(tick_runs[k]);
        end else if (row.n_runs == 1) begin
            pending_runs.push_back('{run_idx: row.run_idx, source: row.source, last: 1'b1});
        end
        @(negedge i_clk);
    endtask

    // Drop start, then wait until the block has gone quiet
    task automatic settle();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_runs.size() != 0 || busy) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Valid stays high across back-to-back writes. The caller lowers it after
    // the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_PERIODIC_OFF) off_mask = val;
        else if (idx == CFG_TIMEOUT) tmo_mask = val;
        @(negedge i_clk);
    endtask

    task automatic write_masks(input logic [MASK_W-1:0] off, input logic [MASK_W-1:0] tmo);
        write_reg(CFG_PERIODIC_OFF, off);
        write_reg(CFG_TIMEOUT, tmo);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly small periods and steps, so tasks come due often. Extremes and
    // full-width values show up too.
    function automatic logic [FIELD_W-1:0] pick_period();
        int p;
        p = $urandom_range(99);
        if (p < 8) return '0;
        if (p < 12) return '1;
        if (p < 20) return $urandom;
        return $urandom_range(1, 24);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_elapsed();
        int p;
        p = $urandom_range(99);
        if (p < 4) return '0;
        if (p < 8) return '1;
        if (p < 16) return $urandom;
        return $urandom_range(1, 8);
    endfunction

    function automatic cmd_row_t random_row();
        cmd_row_t row;
        int p;
        p = $urandom_range(99);
        if (p < 40) row.cmd = CMD_TICK;
        else if (p < 60) row.cmd = CMD_SET_PERIODIC;
        else if (p < 72) row.cmd = CMD_SET_ONCE;
        else if (p < 80) row.cmd = CMD_DISABLE;
        else if (p < 90) row.cmd = CMD_REQUEST;
        else if (p < 96) row.cmd = CMD_CLEAR_TIMEOUT;
        else if (p < 98) row.cmd = CMD_RSVD_6;
        else row.cmd = CMD_RSVD_7;
        row.idx     = TASK_W'($urandom);
        row.per     = pick_period();
        row.el      = pick_elapsed();
        row.n_runs  = PREDICTED;
        row.run_idx = '0;
        row.source  = SRC_PERIODIC;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: a run is on the ports for one cycle, taken at the
    // rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        run_t want;
        if (i_rst_n && o_valid) begin
            if (pending_runs.size() == 0) begin
                $error("unexpected run: run_task %0d run_source %0d last %0d",
                       o_run_task, o_run_source, o_last);
                fail_cnt++;
            end else begin
                want = pending_runs.pop_front();
                if (o_run_task !== want.run_idx) begin
                    $error("run_task: expected %0d, actual %0d", want.run_idx, o_run_task);
                    fail_cnt++;
                end
                if (o_run_source !== want.source) begin
                    $error("run_source: expected %0d, actual %0d", want.source, o_run_source);
                    fail_cnt++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_last);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: any command item, run or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        cmd_row_t         row;
        int               counted;
        logic [MASK_W-1:0] off;
        logic [MASK_W-1:0] tmo;

        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_cmd           = CMD_TICK;
        i_task_index    = '0;
        i_period_ticks  = '0;
        i_elapsed_ticks = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_PERIODIC_OFF;
        i_cfg_data      = '0;
        table_reset();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Spare register indexes must be dropped. The directed results below
        // depend on the masks written after them.
        write_reg(CFG_SPARE_2, 16'hFFFF);
        write_reg(CFG_SPARE_3, 16'h5A5A);
        // Tasks 1, 2, 15: periodic off. Tasks 2, 15: timeout tasks.
        write_masks(16'h8006, 16'h8004);

        // Directed part: every task starts disabled, and a zero step is a no-op
        add_row(CMD_TICK,          4'd0,  32'd0,          32'd5,          0, 4'd0, SRC_PERIODIC);
        add_row(CMD_TICK,          4'd15, 32'hFFFF_FFFF,  32'd0,          0, 4'd0, SRC_PERIODIC);
        // A period of zero is due on every nonzero tick
        add_row(CMD_SET_PERIODIC,  4'd0,  32'd0,          32'd0, PREDICTED, 4'd0, SRC_PERIODIC);
        add_row(CMD_TICK,          4'd0,  32'd0,          32'd1,          1, 4'd0, SRC_PERIODIC);
        add_row(CMD_SET_ONCE,      4'd1,  32'd10,         32'd0, PREDICTED, 4'd0, SRC_PERIODIC);
        add_row(CMD_TICK,          4'd0,  32'd0,          32'd3,          1, 4'd0, SRC_PERIODIC);
        // Counters saturate. The run-once task fires, then stays off.
        add_row(CMD_TICK,          4'd0,  32'd0,  32'hFFFF_FFFF, PREDICTED, 4'd0, SRC_PERIODIC);
        add_row(CMD_TICK,          4'd0,  32'd0,          32'd1, PREDICTED, 4'd0, SRC_PERIODIC);
        // A timeout task with periodic off fires exactly at its period
        add_row(CMD_SET_PERIODIC,  4'd2,  32'd100,        32'd0, PREDICTED, 4'd0, SRC_PERIODIC);
        add_row(CMD_DISABLE,       4'd0,  32'd0,          32'd0, PREDICTED, 4'd0, SRC_PERIODIC);
        add_row(CMD_TICK,          4'd0,  32'd0,          32'd99,         0, 4'd0, SRC_PERIODIC);
        add_row(CMD_TICK,          4'd0,  32'd0,          32'd1,          1, 4'd2, SRC_TIMEOUT);
        add_row(CMD_CLEAR_TIMEOUT, 4'd2,  32'd0,          32'd0, PREDICTED, 4'd0, SRC_PERIODIC);
        // A request on a task that never comes due
        add_row(CMD_SET_PERIODIC,  4'd4,  32'hFFFF_FFFF,  32'd0, PREDICTED, 4'd0, SRC_PERIODIC);
        add_row(CMD_REQUEST,       4'd4,  32'd0,          32'd0, PREDICTED, 4'd0, SRC_PERIODIC);
        add_row(CMD_TICK,          4'd0,  32'd0,          32'd7,          1, 4'd4, SRC_EVENT);
        // Clear timeout on a plain task, and the reserved codes, do nothing
        add_row(CMD_CLEAR_TIMEOUT, 4'd5,  32'd0,          32'd0, PREDICTED, 4'd0, SRC_PERIODIC);
        add_row(CMD_RSVD_6,        4'd3,  32'd1,          32'd1, PREDICTED, 4'd0, SRC_PERIODIC);
        add_row(CMD_RSVD_7,        4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PREDICTED, 4'd0,
                SRC_PERIODIC);
        // Highest task index, run-once with periodic off
        add_row(CMD_SET_ONCE,      4'd15, 32'd0,          32'd0, PREDICTED, 4'd0, SRC_PERIODIC);
        add_row(CMD_TICK,          4'd0,  32'd0,          32'd1,          1, 4'd15, SRC_ONCE);
        // A request re-enables a disabled task. Several runs in one tick.
        add_row(CMD_REQUEST,       4'd0,  32'd0,          32'd0, PREDICTED, 4'd0, SRC_PERIODIC);
        add_row(CMD_TICK,          4'd0,  32'd0,  32'hFFFF_FFFF, PREDICTED, 4'd0, SRC_PERIODIC);
        add_row(CMD_DISABLE,       4'd4,  32'd0,          32'd0, PREDICTED, 4'd0, SRC_PERIODIC);
        add_row(CMD_TICK,          4'd0,  32'd0,          32'd2, PREDICTED, 4'd0, SRC_PERIODIC);

        idle_pct = 0;
        foreach (directed_rows[k]) send_cmd(directed_rows[k]);

        // Random phases. Each one has its own mask setting and sender gap rate.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin off = '0; tmo = '0; idle_pct = 0; end
                1: begin off = '1; tmo = '1; idle_pct = 67; end
                2: begin off = '1; tmo = '0; idle_pct = 9; end
                3: begin off = '0; tmo = '1; idle_pct = 0; end
                default: begin
                    off = MASK_W'($urandom);
                    tmo = MASK_W'($urandom);
                    idle_pct = (ph == 4) ? 67 : 9;
                end
            endcase
            settle();
            write_masks(off, tmo);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                row = random_row();
                send_cmd(row);
                // Items the block merely ignores do not count toward the phase
                if (!(row.cmd > CMD_CLEAR_TIMEOUT ||
                      (row.cmd == CMD_TICK && row.el == '0) ||
                      (row.cmd == CMD_CLEAR_TIMEOUT && !mask_hit(tmo_mask, row.idx)))) begin
                    counted++;
                end
            end
        end

        settle();
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pts_pkg.sv
rtl/pts_alu.sv
rtl/periodic_task_scheduler.sv
sim/tb_periodic_task_scheduler.sv
